// File: hw/rtl/set_assoc_writeback_cache_directory_top_macros.svh
// assertion macros for the cache directory checker
`ifndef SET_ASSOC_WRITEBACK_CACHE_DIRECTORY_TOP_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_DIRECTORY_TOP_MACROS_SVH

// checked only outside reset
`define SACD_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sacd assertion failed");

// checked at every edge, reset included
`define SACD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("sacd assertion failed");

`endif

// File: hw/rtl/sacd_pkg.sv
// types, constants and helpers shared by the cache directory modules
package sacd_pkg;

  localparam int ADDR_W    = 27;
  localparam int WAY_OUT_W = 4;
  localparam int SEED_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SEED_W-1:0] SEED_RESET = 16'hACE1;
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

  typedef enum logic {
    REG_LFSR_SEED = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 victim_dirty;
    logic [ADDR_W-1:0]    victim_line_addr;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] sh;
    sh = {1'b0, s[SEED_W-1:1]};
    return s[0] ? (sh ^ LFSR_TAPS) : sh;
  endfunction

endpackage

// File: hw/rtl/sacd_ctrl.sv
// controller: reset clearing pass, request accept and commit sequencing
module sacd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sacd_pkg::sts_t sts,
  output sacd_pkg::cmd_t cmd
);
  import sacd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd          = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: hw/rtl/sacd_dp.sv
// datapath: set memory, tag compare, way choice, replacement lfsr, result register
module sacd_dp #(
  parameter int NUM_WAYS   = 16,
  parameter int NUM_SETS   = 4096,
  parameter int LINE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sacd_pkg::cmd_t                cmd,
  output sacd_pkg::sts_t                sts,
  input  sacd_pkg::req_t                req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output sacd_pkg::rsp_t                rsp_data,
  input  logic                          cfg_we,
  input  logic [sacd_pkg::SEED_W-1:0]   cfg_wdata,
  output logic [sacd_pkg::SEED_W-1:0]   seed
);
  import sacd_pkg::*;

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(NUM_SETS);
  localparam int TAG_W = ADDR_W - OFF_W - SET_W;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int ENT_W = TAG_W + 2;
  localparam int ROW_W = NUM_WAYS * ENT_W;
  localparam int SUM_W = WAY_W + 4;
  localparam int WAYX_W = (WAY_W > WAY_OUT_W) ? WAY_W : WAY_OUT_W;
  localparam int HALF = SEED_W / 2;

  // entry layout: {valid, dirty, tag}
  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rdata;
  req_t             req;
  logic [SET_W-1:0] clr_cnt;
  logic [SEED_W-1:0] lfsr;
  logic [WAY_W-1:0]  pick;
  logic [WAY_W-1:0]  pick_next;

  logic [SET_W-1:0] set_idx;
  logic [TAG_W-1:0] tag;
  logic [NUM_WAYS-1:0] match;
  logic [NUM_WAYS-1:0] inval;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    way;
  logic                hit;
  logic                evict;
  logic [ENT_W-1:0]    ent;
  logic [ENT_W-1:0]    vent;
  logic [ROW_W-1:0]    new_row;
  logic                mem_we;
  logic [SET_W-1:0]    wr_set;
  logic [ROW_W-1:0]    wr_row;
  logic [WAYX_W-1:0]   way_x;
  rsp_t                rsp_next;

  logic [SEED_W-1:0] lfsr_nx;
  logic [SUM_W-1:0]  sum_lo;
  logic [SUM_W-1:0]  sum_hi;
  logic [SUM_W-1:0]  sum_all;

  function automatic logic [WAY_W-1:0] pow2_res(input int i);
    int r;
    r = 1;
    for (int j = 0; j < i; j++) begin
      r = r * 2;
      if (r >= NUM_WAYS) begin
        r = r - NUM_WAYS;
      end
    end
    return WAY_W'(r);
  endfunction

  assign set_idx = req.addr[OFF_W +: SET_W];
  assign tag     = req.addr[ADDR_W-1 -: TAG_W];

  // lookup over the ways of the set
  always_comb begin
    match    = '0;
    inval    = '0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      ent      = rdata[w*ENT_W +: ENT_W];
      match[w] = ent[ENT_W-1] && (ent[TAG_W-1:0] == tag);
      inval[w] = !ent[ENT_W-1];
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inval[w]) begin
        free_way = WAY_W'(w);
      end
    end
    hit   = |match;
    evict = !hit && !(|inval);
    if (hit) begin
      way = hit_way;
    end else if (|inval) begin
      way = free_way;
    end else begin
      way = pick;
    end
    vent    = rdata[pick*ENT_W +: ENT_W];
    new_row = rdata;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        if (hit) begin
          new_row[w*ENT_W + TAG_W] = rdata[w*ENT_W + TAG_W] | req.action;
        end else begin
          new_row[w*ENT_W +: ENT_W] = {1'b1, req.action, tag};
        end
      end
    end
  end

  always_comb begin
    way_x                     = WAYX_W'(way);
    rsp_next.hit              = hit;
    rsp_next.way              = way_x[WAY_OUT_W-1:0];
    rsp_next.victim_dirty     = evict && vent[TAG_W];
    rsp_next.victim_line_addr = evict ? {vent[TAG_W-1:0], set_idx, {OFF_W{1'b0}}}
                                      : '0;
  end

  // set memory, one row per set
  assign mem_we = cmd.clear_wr || cmd.commit;
  assign wr_set = cmd.clear_wr ? clr_cnt : set_idx;
  assign wr_row = cmd.clear_wr ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_set] <= wr_row;
    end
    if (cmd.start) begin
      rdata <= mem[req_data.addr[OFF_W +: SET_W]];
      req   <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt == SET_W'(NUM_SETS - 1));
  assign sts.out_free   = !rsp_valid || rsp_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data <= rsp_next;
    end
  end

  // replacement lfsr and seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
      lfsr <= SEED_RESET;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
      lfsr <= (cfg_wdata == '0) ? SEED_W'(1) : cfg_wdata;
    end else if (cmd.commit && evict) begin
      lfsr <= lfsr_nx;
    end
  end

  // way for the next eviction: stepped lfsr mod way count, by bit residues
  always_comb begin
    lfsr_nx = lfsr_step(lfsr);
    sum_lo  = '0;
    sum_hi  = '0;
    for (int i = 0; i < HALF; i++) begin
      if (lfsr_nx[i]) begin
        sum_lo = sum_lo + SUM_W'(pow2_res(i));
      end
      if (lfsr_nx[i + HALF]) begin
        sum_hi = sum_hi + SUM_W'(pow2_res(i + HALF));
      end
    end
    sum_all = sum_lo + sum_hi;
    for (int k = 3; k >= 0; k--) begin
      if (sum_all >= SUM_W'(NUM_WAYS << k)) begin
        sum_all = sum_all - SUM_W'(NUM_WAYS << k);
      end
    end
    pick_next = sum_all[WAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    pick <= pick_next;
  end

endmodule

// File: hw/rtl/set_assoc_writeback_cache_directory_top.sv
// top level of the set-associative write-back cache tag directory
// Tag directory for a NUM_WAYS-way write-back, write-allocate cache. Each request
// (read or write plus byte address) gets one response: hit, the way hit or
// allocated, and on an eviction the victim's dirty flag and line address. A
// request first reads the set's row from the single-port set memory, then compares
// the tags and writes the updated row back; a response
// waits in an output register, and a request taken while that register still
// holds an unaccepted response stays in its compare step until the response
// has left or is leaving. After reset a clearing pass writes every set row,
// and no request is taken until it ends; meanwhile the lfsr_seed register
// (address 0) stays writable and reloads the replacement LFSR at once.
module set_assoc_writeback_cache_directory_top #(
  parameter int NUM_WAYS   = 16,
  parameter int NUM_SETS   = 4096,
  parameter int LINE_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  sacd_pkg::req_t                    req_data,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output sacd_pkg::rsp_t                    rsp_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sacd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sacd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sacd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import sacd_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              seed_sel;
  logic              cfg_we;
  logic [SEED_W-1:0] seed;

  assign pready   = 1'b1;
  assign seed_sel = (paddr[CFG_ADDR_W-1:2] == REG_LFSR_SEED);
  assign cfg_we   = psel && penable && pwrite && pready && seed_sel;
  assign prdata   = seed_sel ? CFG_DATA_W'(seed) : '0;

  sacd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sacd_dp #(
    .NUM_WAYS   (NUM_WAYS),
    .NUM_SETS   (NUM_SETS),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[SEED_W-1:0]),
    .seed      (seed)
  );

endmodule

// File: hw/rtl/sacd_checker.sv
// port-level checker for the cache directory, bound to the top level
`include "set_assoc_writeback_cache_directory_top_macros.svh"

module sacd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input sacd_pkg::rsp_t rsp_data,
  input logic           pready
);
  import sacd_pkg::*;

  `SACD_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !req_ready && !rsp_valid)
  `SACD_ASSERT(a_one_in_flight, clk, rst, req_valid && req_ready |=> !req_ready)
  `SACD_ASSERT(a_hit_no_victim, clk, rst, rsp_valid && rsp_data.hit |-> !rsp_data.victim_dirty && rsp_data.victim_line_addr == '0)
  `SACD_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
  `SACD_ASSERT_ALWAYS(a_pready_high, clk, pready)

endmodule

bind set_assoc_writeback_cache_directory_top sacd_checker u_sacd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data),
  .pready    (pready)
);
